// ===== design/bmheap_pkg.sv =====
// ----------------------------------------------------------------------------
// bmheap_pkg: shared types and constants for the binary max-heap core
// Sizes, status codes, index helpers and the command/status structs that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package bmheap_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int LINK_W   = ADDR_W + 2;
  localparam int TOTAL_W  = 7;
  localparam int STATUS_W = 2;

  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic start_ins;
    logic start_ext;
    logic load;
    logic step_up;
    logic step_down;
    logic finish;
  } bmh_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last_one;
    logic up_done;
    logic down_done;
    logic out_free;
  } bmh_sts_t;

  function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] dec;
    dec = p - ADDR_W'(1);
    return dec >> 1;
  endfunction

  // 2p+1, wide enough to compare against the entry count
  function automatic logic [LINK_W-1:0] left_of(input logic [ADDR_W-1:0] p);
    return {1'b0, p, 1'b1};
  endfunction

endpackage

// ===== design/bmheap_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmheap_ctrl: operation sequencer
// Accepts one item, steps the datapath through sift-up or sift-down one
// level per cycle and hands the result to the output register.
// ----------------------------------------------------------------------------
module bmheap_ctrl
  import bmheap_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     action_i,
  output logic     in_stall_o,
  input  bmh_sts_t sts_i,
  output bmh_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UP   = 5'b00010,
    S_LOAD = 5'b00100,
    S_DOWN = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (action_i == ACT_INSERT) begin
            cmd_o.start_ins = 1'b1;
            state_d = sts_i.full ? S_FIN : S_UP;
          end else begin
            cmd_o.start_ext = 1'b1;
            // nothing left to reorder when the heap empties
            state_d = (sts_i.empty || sts_i.last_one) ? S_FIN : S_LOAD;
          end
        end
      end
      S_UP: begin
        cmd_o.step_up = 1'b1;
        if (sts_i.up_done) state_d = S_FIN;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d = S_DOWN;
      end
      S_DOWN: begin
        cmd_o.step_down = 1'b1;
        if (sts_i.down_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== design/bmheap_dp.sv =====
// ----------------------------------------------------------------------------
// bmheap_dp: heap storage and sift datapath
// Holds the heap memory, the entry count, a copy of the root and the
// output register. The moving value stays in a register while the hole
// walks up or down; each step writes one slot.
// ----------------------------------------------------------------------------
module bmheap_dp
  import bmheap_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bmh_cmd_t                   cmd_i,
  output bmh_sts_t                   sts_o,
  input  logic signed [DATA_W-1:0]   value_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic signed [DATA_W-1:0]   extracted_o,
  output logic signed [DATA_W-1:0]   top_value_o,
  output logic [TOTAL_W-1:0]         entry_total_o,
  output logic [STATUS_W-1:0]        status_o
);

  logic [DATA_W-1:0] mem [CAPACITY];

  logic [DATA_W-1:0]        rd_a_q, rd_b_q;
  logic [ADDR_W-1:0]        raddr_a, raddr_b, waddr;
  logic [DATA_W-1:0]        wdata;
  logic                     we;

  logic signed [DATA_W-1:0] val_q, val_d;
  logic [ADDR_W-1:0]        pos_q, pos_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic signed [DATA_W-1:0] top_q;
  logic signed [DATA_W-1:0] got_q, got_d;
  logic [STATUS_W-1:0]      stat_q, stat_d;

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] ext_o_q, top_o_q;
  logic [TOTAL_W-1:0]       total_o_q;
  logic [STATUS_W-1:0]      status_o_q;

  logic [LINK_W-1:0]        lc, rc, count_w, pos_next_lc;
  logic                     up_move, l_pick, r_pick, down_move;
  logic signed [DATA_W-1:0] bval;
  logic [ADDR_W-1:0]        bidx;

  // sift decisions
  always_comb begin
    lc      = left_of(pos_q);
    rc      = lc + LINK_W'(1);
    count_w = LINK_W'(count_q);
    up_move = (pos_q != '0) && (val_q > $signed(rd_a_q));
    l_pick  = (lc < count_w) && ($signed(rd_a_q) > val_q);
    bval    = l_pick ? $signed(rd_a_q) : val_q;
    bidx    = l_pick ? lc[ADDR_W-1:0] : pos_q;
    r_pick  = (rc < count_w) && ($signed(rd_b_q) > bval);
    if (r_pick) begin
      bval = $signed(rd_b_q);
      bidx = rc[ADDR_W-1:0];
    end
    down_move = l_pick || r_pick;
  end

  always_comb begin
    val_d   = val_q;
    pos_d   = pos_q;
    count_d = count_q;
    got_d   = got_q;
    stat_d  = stat_q;
    we      = 1'b0;
    waddr   = pos_q;
    wdata   = val_q;

    if (cmd_i.start_ins) begin
      got_d = '0;
      if (count_q == CNT_W'(CAPACITY)) begin
        stat_d = ST_FULL;
      end else begin
        stat_d  = ST_OK;
        val_d   = value_i;
        pos_d   = ADDR_W'(count_q);
        count_d = count_q + CNT_W'(1);
      end
    end
    if (cmd_i.start_ext) begin
      if (count_q == '0) begin
        stat_d = ST_EMPTY;
        got_d  = '0;
      end else begin
        stat_d  = ST_OK;
        got_d   = top_q;
        count_d = count_q - CNT_W'(1);
      end
    end
    if (cmd_i.load) begin
      val_d = $signed(rd_a_q);
      pos_d = '0;
    end
    if (cmd_i.step_up) begin
      we = 1'b1;
      if (up_move) begin
        wdata = rd_a_q;
        pos_d = parent_of(pos_q);
      end
    end
    if (cmd_i.step_down) begin
      we = 1'b1;
      if (down_move) begin
        wdata = bval;
        pos_d = bidx;
      end
    end

    // fetch for the next step, addressed from the next hole position (an extract start fetches the last entry instead)
    pos_next_lc = left_of(pos_d);
    raddr_b     = ADDR_W'(pos_next_lc + LINK_W'(1));
    if (cmd_i.start_ext) begin
      raddr_a = ADDR_W'(count_q - CNT_W'(1));
    end else if (cmd_i.start_ins || cmd_i.step_up) begin
      raddr_a = parent_of(pos_d);
    end else begin
      raddr_a = pos_next_lc[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_a_q <= mem[raddr_a];
    rd_b_q <= mem[raddr_b];
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    pos_q  <= pos_d;
    got_q  <= got_d;
    stat_q <= stat_d;
    // mirror the root slot
    if (we && (waddr == '0)) top_q <= $signed(wdata);
    if (cmd_i.finish) begin
      ext_o_q    <= got_q;
      top_o_q    <= (count_q != '0) ? top_q : '0;
      total_o_q  <= TOTAL_W'(count_q);
      status_o_q <= stat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.full      = (count_q == CNT_W'(CAPACITY));
    sts_o.empty     = (count_q == '0);
    sts_o.last_one  = (count_q == CNT_W'(1));
    sts_o.up_done   = !up_move;
    sts_o.down_done = !down_move;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o   = out_valid_q;
  assign extracted_o   = ext_o_q;
  assign top_value_o   = top_o_q;
  assign entry_total_o = total_o_q;
  assign status_o      = status_o_q;

endmodule

// ===== design/binary_max_heap_core.sv =====
// ----------------------------------------------------------------------------
// binary_max_heap_core: priority queue of signed 32-bit values
// Each input item inserts value_i (action_i = 0) or extracts the maximum
// (action_i = 1). Each item yields one result item with the removed
// maximum, the new top, the entry count and a status code (ok, insert
// dropped because full, extract on empty).
// Both channels move an item when valid is high and stall is low.
// The heap lives in a memory with one write and two read ports; sift-up and
// sift-down handle one heap level per cycle, and that memory port sets
// the pace. An insert climbs level by level; an extract first loads the
// last entry into the root hole and then descends level by level. A
// dropped insert, an extract on empty and an extract of the last entry
// skip the sift and go straight to completion.
// in_stall_o is high while an item is being worked on. A finished result
// sits in an output register; while the receiver stalls it holds there,
// the next item may still be accepted and processed, and its completion
// waits until the register frees up.
// Reset empties the heap and clears the output valid flag; heap slots are
// not cleared, since only slots below the count are ever used.
// ----------------------------------------------------------------------------
module binary_max_heap_core
  import bmheap_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] extracted_o,
  output logic signed [DATA_W-1:0] top_value_o,
  output logic [TOTAL_W-1:0]       entry_total_o,
  output logic [STATUS_W-1:0]      status_o
);

  bmh_cmd_t cmd;
  bmh_sts_t sts;

  bmheap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bmheap_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (value_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .extracted_o   (extracted_o),
    .top_value_o   (top_value_o),
    .entry_total_o (entry_total_o),
    .status_o      (status_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item accepted while one is in progress");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL)
      |-> (entry_total_o == TOTAL_W'(CAPACITY)) && (extracted_o == '0))
    else $error("dropped insert reported with wrong count or value");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY)
      |-> (entry_total_o == '0) && (top_value_o == '0) && (extracted_o == '0))
    else $error("extract on empty reported nonzero fields");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !out_valid_o || !out_stall_i)
    else $error("result register overwritten while stalled");

endmodule

// ===== tb/bmheap_checker.sv =====
// ----------------------------------------------------------------------------
// bmheap_checker: result checker for the binary max-heap core
// Watches both channels. Every accepted input item is run through a private
// copy of the heap to predict its result item; every accepted result item is
// compared field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module bmheap_checker
  import bmheap_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     action_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [DATA_W-1:0] extracted_i,
  input  logic signed [DATA_W-1:0] top_value_i,
  input  logic [TOTAL_W-1:0]       entry_total_i,
  input  logic [STATUS_W-1:0]      status_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       inserts_o,
  output int                       extracts_o,
  output int                       drops_o,
  output int                       empties_o,
  output int                       full_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DATA_W-1:0] extracted;
    logic signed [DATA_W-1:0] top_value;
    logic [TOTAL_W-1:0]       entry_total;
    logic [STATUS_W-1:0]      status;
  } heap_outcome_t;

  logic signed [DATA_W-1:0] model_heap [CAPACITY];
  int                       model_count;
  heap_outcome_t            heap_outcomes [$];

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Apply one insert or extract to the private heap and return its result.
  function automatic heap_outcome_t apply_heap_op(input logic act,
                                                  input logic signed [DATA_W-1:0] val);
    heap_outcome_t            res;
    int                       pos;
    int                       parent;
    int                       best;
    int                       lc;
    int                       rc;
    logic signed [DATA_W-1:0] tmp;
    res = '0;
    res.status = ST_OK;
    if (act == ACT_INSERT) begin
      if (model_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        pos = model_count;
        model_heap[pos] = val;
        model_count++;
        // climb while strictly larger than the parent
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (model_heap[pos] <= model_heap[parent]) break;
          tmp = model_heap[pos];
          model_heap[pos] = model_heap[parent];
          model_heap[parent] = tmp;
          pos = parent;
        end
      end
    end else if (model_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.extracted = model_heap[0];
      model_count--;
      model_heap[0] = model_heap[model_count];
      pos = 0;
      // descend to a strictly larger child, left wins a tie
      forever begin
        best = pos;
        lc = 2 * pos + 1;
        rc = 2 * pos + 2;
        if (lc < model_count && model_heap[lc] > model_heap[best]) best = lc;
        if (rc < model_count && model_heap[rc] > model_heap[best]) best = rc;
        if (best == pos) break;
        tmp = model_heap[pos];
        model_heap[pos] = model_heap[best];
        model_heap[best] = tmp;
        pos = best;
      end
    end
    res.top_value = (model_count > 0) ? model_heap[0] : '0;
    res.entry_total = TOTAL_W'(model_count);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heap_outcome_t want;
    if (!rst_ni) begin
      model_count = 0;
      heap_outcomes.delete();
      fail_count_o = 0;
      pending_o = 0;
      inserts_o = 0;
      extracts_o = 0;
      drops_o = 0;
      empties_o = 0;
      full_hits_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (heap_outcomes.size() == 0) begin
          report_mismatch("unexpected item", {DATA_W{1'b0}}, {DATA_W{1'b0}});
        end else begin
          want = heap_outcomes.pop_front();
          if (extracted_i !== want.extracted)
            report_mismatch("extracted", extracted_i, want.extracted);
          if (top_value_i !== want.top_value)
            report_mismatch("top_value", top_value_i, want.top_value);
          if (entry_total_i !== want.entry_total)
            report_mismatch("entry_total", DATA_W'(entry_total_i), DATA_W'(want.entry_total));
          if (status_i !== want.status)
            report_mismatch("status", DATA_W'(status_i), DATA_W'(want.status));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = apply_heap_op(action_i, value_i);
        heap_outcomes.push_back(want);
        case (want.status)
          ST_FULL:  drops_o++;
          ST_EMPTY: empties_o++;
          default: begin
            if (action_i == ACT_INSERT) begin
              inserts_o++;
              if (model_count == CAPACITY) full_hits_o++;
            end else begin
              extracts_o++;
            end
          end
        endcase
      end
      pending_o = heap_outcomes.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top for the binary max-heap core
// Drives a short directed sequence (empty extract, extreme and equal values,
// full drain) and then random insert/extract bursts that fill the heap past
// capacity and drain it past empty, under three idle/stall regimes. The
// checker instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import bmheap_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1900;
  localparam int SETTLE_CYCLES = 20;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     action = ACT_INSERT;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] extracted;
  logic signed [DATA_W-1:0] top_value;
  logic [TOTAL_W-1:0]       entry_total;
  logic [STATUS_W-1:0]      status;

  int fail_count;
  int pending;
  int inserts;
  int extracts;
  int drops;
  int empties;
  int full_hits;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #5 clk = ~clk;

  binary_max_heap_core u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .value_i      (value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .extracted_o  (extracted),
    .top_value_o  (top_value),
    .entry_total_o(entry_total),
    .status_o     (status)
  );

  bmheap_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .action_i     (action),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .extracted_i  (extracted),
    .top_value_i  (top_value),
    .entry_total_i(entry_total),
    .status_i     (status),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .inserts_o    (inserts),
    .extracts_o   (extracts),
    .drops_o      (drops),
    .empties_o    (empties),
    .full_hits_o  (full_hits)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Offer one item after a random gap; return at the falling edge after
  // it is taken, with valid left high.
  task automatic send_item(input logic act, input logic signed [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      action = 1'($urandom);
      value = $urandom;
      @(negedge clk);
    end
    in_valid = 1'b1;
    action = act;
    value = val;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold off until every predicted result item has arrived.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(input int mode);
    case (mode)
      0: return $urandom_range(0, 8) - 4;
      1: begin
        case ($urandom_range(0, 5))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sh7ffffffe;
          3: return 32'sh80000001;
          4: return 0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int sent;
    int quota;
    int seg_len;
    int ins_pct;
    int val_mode;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_idle_pct = 25;
    recv_stall_pct = 73;

    // directed: empty extract, extremes, equal values, full drain to empty
    send_item(ACT_EXTRACT, 32'sh12345678);
    send_item(ACT_INSERT, 0);
    send_item(ACT_INSERT, 32'sh7fffffff);
    send_item(ACT_INSERT, 32'sh80000000);
    send_item(ACT_INSERT, -1);
    send_item(ACT_INSERT, 5);
    send_item(ACT_INSERT, 5);
    send_item(ACT_INSERT, 5);
    send_item(ACT_INSERT, 32'sh7fffffff);
    repeat (9) send_item(ACT_EXTRACT, $urandom);
    send_item(ACT_INSERT, 32'sh55555555);
    send_item(ACT_INSERT, 32'shaaaaaaaa);
    send_item(ACT_EXTRACT, 32'shffffffff);
    send_item(ACT_EXTRACT, 0);
    wait_drained();

    // random bursts: insert-heavy ones fill past capacity, extract-heavy
    // ones drain past empty
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 25;
          recv_stall_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_stall_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      quota = (phase == 2) ? RANDOM_ITEMS : RANDOM_ITEMS * (phase + 1) / 3;
      while (sent < quota) begin
        seg_len = $urandom_range(30, 120);
        case ($urandom_range(0, 2))
          0: ins_pct = 15;
          1: ins_pct = 50;
          default: ins_pct = 92;
        endcase
        val_mode = $urandom_range(0, 3);
        for (int k = 0; k < seg_len && sent < quota; k++) begin
          if ($urandom_range(0, 99) < ins_pct)
            send_item(ACT_INSERT, pick_value(val_mode));
          else
            send_item(ACT_EXTRACT, $urandom);
          sent++;
        end
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("covered %0d inserts, %0d extracts, %0d inserts dropped on full, %0d extracts on empty",
             inserts, extracts, drops, empties);
    $display("heap filled to capacity %0d times under three idle/stall regimes", full_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
